// ----- hw/rtl/kfwrl_pkg.sv -----
`default_nettype none

package kfwrl_pkg;

    localparam int CLIENT_W = 16;
    localparam int CHANNEL_W = 16;
    localparam int TIME_W = 32;
    localparam int COUNT_W = 16;
    localparam int CFG_W = 16;
    localparam int FREED_W = 7;

    localparam logic [1:0] MODE_CHECK = 2'd0;
    localparam logic [1:0] MODE_RECORD = 2'd1;
    localparam logic [1:0] MODE_SWEEP = 2'd2;
    localparam logic [1:0] MODE_IDLE = 2'd3;

    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 16'd60;
    localparam logic [CFG_W-1:0] LIMIT_RESET = 16'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [FREED_W-1:0] FREED_MAX = '1;

    typedef struct packed {
        logic                 valid;
        logic [CLIENT_W-1:0]  client;
        logic [CHANNEL_W-1:0] channel;
        logic [TIME_W-1:0]    start;
        logic [COUNT_W-1:0]   count;
    } t_entry;

endpackage

`default_nettype wire

// ----- hw/rtl/keyed_fixed_window_rate_limiter.sv -----
// Channel   Direction  Handshake            Payload
// item      in         start, busy          i_mode, i_client_id, i_channel_id,
//                                           i_now_seconds, i_is_local_user, i_is_immune
// result    out        o_done (one cycle)   o_throttled, o_table_full, o_freed_count
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// A check, record or sweep that touches the table scans every entry through the
// single read port of the table memory, with busy high; o_done rises in the same
// cycle that busy falls. Items that need no scan go straight to the finish step.
// After reset a clearing pass writes every entry, with busy high.
// o_done is high for one cycle only; the receiver cannot stall the results.
`default_nettype none

module keyed_fixed_window_rate_limiter
    import kfwrl_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire  [1:0]           i_mode,
    input  wire  [CLIENT_W-1:0]  i_client_id,
    input  wire  [CHANNEL_W-1:0] i_channel_id,
    input  wire  [TIME_W-1:0]    i_now_seconds,
    input  wire                  i_is_local_user,
    input  wire                  i_is_immune,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_index,
    input  wire  [CFG_W-1:0]     i_cfg_data,
    output logic                 o_done,
    output logic                 o_throttled,
    output logic                 o_table_full,
    output logic [FREED_W-1:0]   o_freed_count
);

    localparam int ADDR_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] END = CNT_W'(ENTRIES);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_window;
    logic [CFG_W-1:0]     r_limit;

    logic [1:0]           r_mode;
    logic [CLIENT_W-1:0]  r_client;
    logic [CHANNEL_W-1:0] r_channel;
    logic [TIME_W-1:0]    r_now;

    logic [CNT_W-1:0]     r_issue;
    logic                 r_pend;
    logic [ADDR_W-1:0]    r_pend_addr;
    logic                 r_hit;
    logic [ADDR_W-1:0]    r_hit_addr;
    t_entry               r_hit_ent;
    logic                 r_hit_run;
    logic                 r_free_found;
    logic [ADDR_W-1:0]    r_free_addr;
    logic [FREED_W-1:0]   r_freed;

    logic                 r_done;
    logic                 r_throttled;
    logic                 r_table_full;
    logic [FREED_W-1:0]   r_freed_count;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    t_entry               wr_data;
    logic                 rd_en;
    t_entry               rd_data;
    logic [TIME_W-1:0]    elapsed;
    logic                 running;
    logic                 match;
    logic                 scan_needed;
    logic [COUNT_W-1:0]   next_count;

    kfwrl_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign elapsed = r_now - rd_data.start;
    assign running = elapsed < {{(TIME_W - CFG_W){1'b0}}, r_window};
    assign match = rd_data.valid && (rd_data.client == r_client)
                   && (rd_data.channel == r_channel);
    assign rd_en = (r_state == ST_SCAN) && (r_issue != END);
    assign next_count = (r_hit_ent.count == COUNT_MAX) ? COUNT_MAX
                        : r_hit_ent.count + COUNT_W'(1);

    always_comb begin
        unique case (i_mode)
            MODE_CHECK:  scan_needed = i_is_local_user && !i_is_immune;
            MODE_RECORD: scan_needed = i_is_local_user;
            MODE_SWEEP:  scan_needed = 1'b1;
            default:     scan_needed = 1'b0;
        endcase
    end

    always_comb begin
        wr_en = 1'b0;
        wr_addr = r_pend_addr;
        wr_data = rd_data;
        wr_data.valid = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                wr_en = 1'b1;
                wr_addr = r_issue[ADDR_W-1:0];
                wr_data = '0;
            end
            ST_SCAN: begin
                wr_en = r_pend && (r_mode == MODE_SWEEP) && rd_data.valid && !running;
            end
            ST_FINISH: begin
                wr_data.valid = 1'b1;
                wr_data.client = r_client;
                wr_data.channel = r_channel;
                wr_data.start = r_now;
                wr_data.count = COUNT_W'(1);
                if (r_mode == MODE_RECORD) begin
                    if (r_hit) begin
                        wr_en = 1'b1;
                        wr_addr = r_hit_addr;
                        if (r_hit_run) begin
                            wr_data.start = r_hit_ent.start;
                            wr_data.count = next_count;
                        end
                    end else if (r_free_found) begin
                        wr_en = 1'b1;
                        wr_addr = r_free_addr;
                    end
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_window <= WINDOW_RESET;
            r_limit <= LIMIT_RESET;
            r_issue <= '0;
            r_pend <= 1'b0;
            r_hit <= 1'b0;
            r_free_found <= 1'b0;
            r_freed <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == ST_FINISH);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WINDOW: r_window <= i_cfg_data;
                    CFG_LIMIT:  r_limit <= i_cfg_data;
                    default:    r_limit <= r_limit;
                endcase
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_issue <= r_issue + CNT_W'(1);
                    if (r_issue == LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_mode <= scan_needed ? i_mode : MODE_IDLE;
                        r_client <= i_client_id;
                        r_channel <= i_channel_id;
                        r_now <= i_now_seconds;
                        r_issue <= '0;
                        r_pend <= 1'b0;
                        r_hit <= 1'b0;
                        r_free_found <= 1'b0;
                        r_freed <= '0;
                        r_state <= scan_needed ? ST_SCAN : ST_FINISH;
                    end
                end
                ST_SCAN: begin
                    if (r_pend) begin
                        if (r_mode == MODE_SWEEP) begin
                            if (rd_data.valid && !running && r_freed != FREED_MAX) begin
                                r_freed <= r_freed + FREED_W'(1);
                            end
                        end else begin
                            if (match) begin
                                r_hit <= 1'b1;
                                r_hit_addr <= r_pend_addr;
                                r_hit_ent <= rd_data;
                                r_hit_run <= running;
                            end
                            if (!rd_data.valid && !r_free_found) begin
                                r_free_found <= 1'b1;
                                r_free_addr <= r_pend_addr;
                            end
                        end
                    end
                    // advance the read pointer, one entry a cycle
                    if (r_issue != END) begin
                        r_pend <= 1'b1;
                        r_pend_addr <= r_issue[ADDR_W-1:0];
                        r_issue <= r_issue + CNT_W'(1);
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    r_throttled <= (r_mode == MODE_CHECK) && r_hit && r_hit_run
                                   && (r_hit_ent.count >= r_limit);
                    r_table_full <= (r_mode == MODE_RECORD) && !r_hit && !r_free_found;
                    r_freed_count <= (r_mode == MODE_SWEEP) ? r_freed : '0;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_throttled = r_throttled;
    assign o_table_full = r_table_full;
    assign o_freed_count = r_freed_count;

endmodule

`default_nettype wire

// ----- hw/rtl/kfwrl_table.sv -----
`default_nettype none

module kfwrl_table
    import kfwrl_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire                         i_clk,
    input  wire                         i_wr_en,
    input  wire  [$clog2(ENTRIES)-1:0]  i_wr_addr,
    input  t_entry                      i_wr_data,
    input  wire                         i_rd_en,
    input  wire  [$clog2(ENTRIES)-1:0]  i_rd_addr,
    output t_entry                      o_rd_data
);

    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire
